>>> design/young_diagram_position_hash_macros.svh
// Assertion macros shared by the position hash controller and datapath.
// Depends on nothing; define NO_ASSERTIONS to compile every check away.
`ifndef YOUNG_DIAGRAM_POSITION_HASH_MACROS_SVH
`define YOUNG_DIAGRAM_POSITION_HASH_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising edge outside reset.
`define YDPH_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that pre in one cycle implies post in the next cycle.
`define YDPH_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define YDPH_ASSERT(label, clk, rst, prop, msg)
`define YDPH_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

>>> design/ydph_pkg.sv
// Shared constants and controller/datapath interface types for the position hash.
// Depends on nothing; used by ydph_ctrl, ydph_dp and young_diagram_position_hash.
package ydph_pkg;

  localparam int MaxRowsDefault     = 256;
  localparam int MaxRowWidthDefault = 255;
  localparam int RowW               = 8;
  localparam int HashW              = 64;
  localparam logic [31:0] HashMult  = 32'd179424673;

  typedef struct packed {
    logic accept;     // transaction on the input channel
    logic mul_lo;     // low half partial product
    logic mul_hi;     // high half partial product
    logic sum;        // combine partial products into a hash register
    logic sum_trans;  // route the sum to the transposed hash
    logic walk_read;  // read the stored row below the row counter
    logic walk_step;  // load operand with transposed hash plus row index, advance column
    logic walk_next;  // drop to the next row down
    logic publish;    // move results to the output registers and clear the position
  } dp_cmd_t;

  typedef struct packed {
    logic full;        // row store holds its capacity
    logic count_zero;  // no rows left for the walk
    logic len_gt_col;  // current stored row is longer than the column counter
  } dp_status_t;

endpackage

>>> design/ydph_ctrl.sv
// Controller state machine for the position hash: sequences loads, the shared
// multiplier and the transpose walk. Depends on ydph_pkg and the macros header.
`include "young_diagram_position_hash_macros.svh"

module ydph_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                last_row,
  output logic                out_valid,
  input  logic                out_stall,
  input  ydph_pkg::dp_status_t status,
  output ydph_pkg::dp_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL_LO = 3'd1;
  localparam logic [2:0] S_MUL_HI = 3'd2;
  localparam logic [2:0] S_SUM    = 3'd3;
  localparam logic [2:0] S_W_ADDR = 3'd4;
  localparam logic [2:0] S_W_DATA = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       last_pend;
  logic       last_pend_next;
  logic       walking;
  logic       walking_next;
  logic       out_valid_next;
  logic       slot_free;

  assign in_stall  = (state != S_IDLE);
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    last_pend_next = last_pend;
    walking_next   = walking;
    cmd.sum_trans  = walking;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept     = 1'b1;
          last_pend_next = last_row;
          if (!status.full) begin
            state_next = S_MUL_LO;
          end else if (last_row) begin
            state_next   = S_W_ADDR;
            walking_next = 1'b1;
          end
        end
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum = 1'b1;
        if (walking) begin
          state_next = S_W_DATA;
        end else if (last_pend) begin
          state_next   = S_W_ADDR;
          walking_next = 1'b1;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_W_ADDR: begin
        if (status.count_zero) begin
          state_next = S_FIN;
        end else begin
          cmd.walk_read = 1'b1;
          state_next    = S_W_DATA;
        end
      end
      S_W_DATA: begin
        if (status.len_gt_col) begin
          cmd.walk_step = 1'b1;
          state_next    = S_MUL_LO;
        end else begin
          cmd.walk_next = 1'b1;
          state_next    = S_W_ADDR;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.publish  = 1'b1;
          walking_next = 1'b0;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign out_valid_next = cmd.publish || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      last_pend <= 1'b0;
      walking   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      last_pend <= last_pend_next;
      walking   <= walking_next;
      out_valid <= out_valid_next;
    end
  end

  `YDPH_ASSERT(a_publish_free, clk, rst, cmd.publish |-> slot_free, "publish into a full output slot")
  `YDPH_ASSERT_NEXT(a_hi_then_sum, clk, rst, state == S_MUL_HI, state == S_SUM, "sum did not follow high product")
  `YDPH_ASSERT(a_rose_publish, clk, rst, $rose(out_valid) |-> $past(cmd.publish), "result shown without publish")

endmodule

>>> design/ydph_dp.sv
// Datapath for the position hash: row store, counters, hash registers, the
// shared constant multiplier and the output registers. Depends on ydph_pkg and macros.
`include "young_diagram_position_hash_macros.svh"

module ydph_dp #(
  parameter int MAX_ROWS      = ydph_pkg::MaxRowsDefault,
  parameter int MAX_ROW_WIDTH = ydph_pkg::MaxRowWidthDefault
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [ydph_pkg::RowW-1:0]       row_width,
  input  ydph_pkg::dp_cmd_t               cmd,
  output ydph_pkg::dp_status_t            status,
  output logic [ydph_pkg::HashW-1:0]      forward_hash,
  output logic [ydph_pkg::HashW-1:0]      transposed_hash,
  output logic                            row_overflow
);

  localparam int CNT_W = $clog2(MAX_ROWS + 1);
  localparam int IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int SAT   = (MAX_ROW_WIDTH < 255) ? MAX_ROW_WIDTH : 255;
  localparam logic [ydph_pkg::RowW-1:0] SAT_LEN = ydph_pkg::RowW'(SAT);

  logic [ydph_pkg::RowW-1:0]  row_store [MAX_ROWS];
  logic [ydph_pkg::RowW-1:0]  rd_data;
  logic [ydph_pkg::RowW-1:0]  len_sat;
  logic [ydph_pkg::RowW-1:0]  col;
  logic [CNT_W-1:0]           row_count;
  logic [CNT_W-1:0]           cnt_dec;
  logic [ydph_pkg::HashW-1:0] fwd;
  logic [ydph_pkg::HashW-1:0] trans;
  logic [ydph_pkg::HashW-1:0] opnd;
  logic [ydph_pkg::HashW-1:0] plo;
  logic [31:0]                phi;
  logic [ydph_pkg::HashW-1:0] lo_prod;
  logic [31:0]                hi_prod;
  logic [ydph_pkg::HashW-1:0] prod_sum;
  logic                       overflow_seen;

  assign len_sat  = (row_width > SAT_LEN) ? SAT_LEN : row_width;
  assign cnt_dec  = row_count - CNT_W'(1);
  assign lo_prod  = opnd[31:0] * ydph_pkg::HashMult;
  assign hi_prod  = opnd[63:32] * ydph_pkg::HashMult;
  assign prod_sum = plo + {phi, 32'd0};

  assign status.full       = (row_count == CNT_W'(MAX_ROWS));
  assign status.count_zero = (row_count == '0);
  assign status.len_gt_col = (rd_data > col);

  // Row store: one write port on load, one registered read port for the walk.
  always_ff @(posedge clk) begin
    if (cmd.accept && !status.full) begin
      row_store[row_count[IDX_W-1:0]] <= len_sat;
    end
    if (cmd.walk_read) begin
      rd_data <= row_store[cnt_dec[IDX_W-1:0]];
    end
  end

  // Shared multiplier operand and partial products.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      opnd <= fwd + ydph_pkg::HashW'(len_sat);
    end else if (cmd.walk_step) begin
      opnd <= trans + ydph_pkg::HashW'(row_count);
    end
    if (cmd.mul_lo) begin
      plo <= lo_prod;
    end
    if (cmd.mul_hi) begin
      phi <= hi_prod;
    end
    if (cmd.publish) begin
      forward_hash    <= fwd;
      transposed_hash <= trans;
      row_overflow    <= overflow_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count     <= '0;
      fwd           <= '0;
      trans         <= '0;
      col           <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.publish) begin
      row_count     <= '0;
      fwd           <= '0;
      trans         <= '0;
      col           <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (status.full) begin
          overflow_seen <= 1'b1;
        end else begin
          row_count <= row_count + CNT_W'(1);
        end
      end
      if (cmd.walk_next) begin
        row_count <= cnt_dec;
      end
      if (cmd.walk_step) begin
        col <= col + ydph_pkg::RowW'(1);
      end
      if (cmd.sum) begin
        if (cmd.sum_trans) begin
          trans <= prod_sum;
        end else begin
          fwd <= prod_sum;
        end
      end
    end
  end

  `YDPH_ASSERT(a_count_bound, clk, rst, row_count <= CNT_W'(MAX_ROWS), "row count above capacity")
  `YDPH_ASSERT_NEXT(a_publish_clear, clk, rst, cmd.publish, (row_count == '0) && !overflow_seen && (trans == '0), "position not cleared after publish")
  `YDPH_ASSERT_NEXT(a_col_step, clk, rst, cmd.walk_step, col == ydph_pkg::RowW'($past(col) + ydph_pkg::RowW'(1)), "column did not advance")

endmodule

>>> design/young_diagram_position_hash.sv
// Position hash: forward and transposed polynomial hashes of a staircase board.
// A stored row runs the low product, high product and sum steps; a dropped row is only
// taken. After the last row the walk reads each stored row, runs the multiply steps again
// for each column step, then closes the walk and publishes the transaction.
// Throughput: one row in flight at a time; the shared 32-bit constant multiplier sets it.
// Reset (rst, synchronous) empties the position; the row store keeps stale data and
// needs no clearing pass, since the walk reads only rows written for the current position.
module young_diagram_position_hash #(
  parameter int MAX_ROWS      = ydph_pkg::MaxRowsDefault,
  parameter int MAX_ROW_WIDTH = ydph_pkg::MaxRowWidthDefault
) (
  input  logic                       clk,
  input  logic                       rst,
  // Input channel: one row length per transaction, last_row closes the position.
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ydph_pkg::RowW-1:0]  row_width,
  input  logic                       last_row,
  // Output channel: one transaction per closed position.
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [ydph_pkg::HashW-1:0] forward_hash,
  output logic [ydph_pkg::HashW-1:0] transposed_hash,
  output logic                       row_overflow
);

  // Commands from the controller, status back from the datapath.
  ydph_pkg::dp_cmd_t    cmd;
  ydph_pkg::dp_status_t status;

  // Controller: take a row only when idle, run the multiply steps, walk the
  // stored rows top down, and hold the result until the output slot frees.
  ydph_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .last_row  (last_row),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: saturate and store rows, keep both hashes, multiply by the prime
  // in two 32-bit partial products, and hold the published result registers.
  ydph_dp #(
    .MAX_ROWS      (MAX_ROWS),
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .row_width       (row_width),
    .cmd             (cmd),
    .status          (status),
    .forward_hash    (forward_hash),
    .transposed_hash (transposed_hash),
    .row_overflow    (row_overflow)
  );

endmodule

>>> test/young_diagram_position_hash_test.sv
`timescale 1ns / 1ps
// Self-checking bench for young_diagram_position_hash: rows in, forward and transposed hashes out.
// Depends on ydph_pkg and the block's RTL only; predicts every position in-bench.
module young_diagram_position_hash_test;

  localparam int RowW = ydph_pkg::RowW;
  localparam int HashW = ydph_pkg::HashW;
  localparam int RowCap = ydph_pkg::MaxRowsDefault;
  localparam int WidthCap = ydph_pkg::MaxRowWidthDefault;
  localparam logic [HashW-1:0] HashMult = 64'd179424673;
  localparam int RandomRows = 750;
  localparam int MinRandomPositions = 40;
  localparam int IdlePercent = 27;
  localparam int HoldCycles = 400;
  localparam int SettleCycles = 40;

  typedef struct packed {
    logic [RowW-1:0] width;
    logic            closes;
  } row_t;

  typedef struct packed {
    logic [HashW-1:0] fwd;
    logic [HashW-1:0] trn;
    logic             ovf;
  } position_hash_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [RowW-1:0]  row_width = '0;
  logic             last_row = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [HashW-1:0] forward_hash;
  logic [HashW-1:0] transposed_hash;
  logic             row_overflow;

  young_diagram_position_hash i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .row_width      (row_width),
    .last_row       (last_row),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .forward_hash   (forward_hash),
    .transposed_hash(transposed_hash),
    .row_overflow   (row_overflow)
  );

  // 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Rows waiting to be offered, and hashes of closed positions waiting to come out.
  row_t           rows_to_send[$];
  position_hash_t expected_positions[$];

  // Shadow of the block's position state.
  logic [RowW-1:0]  stored_rows[RowCap];
  int               stored_count = 0;
  logic [HashW-1:0] fwd_acc = '0;
  bit               dropped_any = 1'b0;

  int rows_queued = 0;
  int rows_accepted = 0;
  int results_seen = 0;
  int positions_closed = 0;
  int overflow_positions = 0;
  int errors = 0;

  // Walk the stored rows from the top down; each column step adds the row index plus one,
  // then multiplies. The column counter only moves forward, so out-of-order rows add nothing.
  function automatic logic [HashW-1:0] column_walk_hash();
    logic [HashW-1:0] h;
    int               col;
    h = '0;
    col = 0;
    for (int i = stored_count - 1; i >= 0; i--) begin
      while (int'(stored_rows[i]) > col) begin
        h = (h + HashW'(i + 1)) * HashMult;
        col++;
      end
    end
    return h;
  endfunction

  // Fold one accepted row into the shadow state; on the last row, queue the expected hashes
  // and return to the empty position.
  task automatic absorb_row(input logic [RowW-1:0] w, input logic fin);
    int             len;
    position_hash_t res;
    len = int'(w);
    if (len > WidthCap) len = WidthCap;
    if (stored_count < RowCap) begin
      stored_rows[stored_count] = len[RowW-1:0];
      stored_count++;
      fwd_acc = (fwd_acc + HashW'(len)) * HashMult;
    end else begin
      // Store full: drop the row, keep it out of both hashes, flag it.
      dropped_any = 1'b1;
    end
    if (fin) begin
      res.fwd = fwd_acc;
      res.trn = column_walk_hash();
      res.ovf = dropped_any;
      expected_positions = {expected_positions, res};
      positions_closed++;
      if (dropped_any) overflow_positions++;
      stored_count = 0;
      fwd_acc = '0;
      dropped_any = 1'b0;
    end
  endtask

  task automatic queue_row(input int w, input bit fin);
    row_t r;
    r.width = w[RowW-1:0];
    r.closes = fin;
    rows_to_send = {rows_to_send, r};
    rows_queued++;
  endtask

  // Build one position of n rows. Staircase positions shrink upward with random content;
  // the rest are noise with plenty of zero rows and no ordering at all.
  task automatic queue_position(input int n, input bit staircase);
    int w;
    w = $urandom_range(0, WidthCap);
    for (int k = 0; k < n; k++) begin
      if (!staircase) begin
        w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, WidthCap);
      end else if (k > 0) begin
        w = ($urandom_range(0, 2) == 0) ? $urandom_range(0, w)
                                        : w - $urandom_range(0, (w < 3) ? w : 3);
      end
      queue_row(w, k == n - 1);
    end
  endtask

  // Driver: predict on each accepted transaction, then offer the next row when the slot is
  // free. Hold the payload steady while stalled. Skip the random gaps during a quiet stretch.
  row_t next_row;
  bit   send_gap;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        absorb_row(row_width, last_row);
        rows_accepted++;
      end
      send_gap = (rows_accepted < 300 || rows_accepted >= 460) &&
                 ($urandom_range(0, 99) < IdlePercent);
      if (!in_valid || !in_stall) begin
        if (rows_to_send.size() != 0 && !send_gap) begin
          next_row = rows_to_send.pop_front();
          in_valid <= 1'b1;
          row_width <= next_row.width;
          last_row <= next_row.closes;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expected position, then pick the
  // next stall. Once, early on, hold off for a long stretch so the block backs up into its
  // input while the driver keeps offering rows.
  position_hash_t oldest_position;
  int             hold_left = 0;
  bit             hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_positions.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: forward %h transposed %h overflow %b",
                   $time, forward_hash, transposed_hash, row_overflow);
        end else begin
          oldest_position = expected_positions.pop_front();
          if (forward_hash !== oldest_position.fwd) begin
            errors++;
            $display("%0t: forward_hash expected %h, got %h",
                     $time, oldest_position.fwd, forward_hash);
          end
          if (transposed_hash !== oldest_position.trn) begin
            errors++;
            $display("%0t: transposed_hash expected %h, got %h",
                     $time, oldest_position.trn, transposed_hash);
          end
          if (row_overflow !== oldest_position.ovf) begin
            errors++;
            $display("%0t: row_overflow expected %b, got %b",
                     $time, oldest_position.ovf, row_overflow);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!hold_done && results_seen == 3) begin
        hold_done <= 1'b1;
        hold_left <= HoldCycles;
        out_stall <= 1'b1;
      end else if (results_seen >= 20 && results_seen < 32) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < IdlePercent);
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int pos;
    int n;
    int random_rows;

    // Directed positions: empty, widest single row, a plain staircase, alternating bits,
    // a zero row inside, rows out of order, and a trailing zero row.
    queue_row(0, 1);
    queue_row(WidthCap, 1);
    queue_row(3, 0); queue_row(2, 0); queue_row(2, 0); queue_row(1, 1);
    queue_row(170, 0); queue_row(85, 1);
    queue_row(2, 0); queue_row(0, 0); queue_row(1, 1);
    queue_row(1, 0); queue_row(3, 0); queue_row(2, 1);
    queue_row(WidthCap, 0); queue_row(WidthCap, 0); queue_row(0, 1);

    // Random positions, mostly short staircases. One fills the row store exactly; one runs
    // past it so that the closing row itself is dropped.
    pos = 0;
    random_rows = 0;
    while (random_rows < RandomRows || pos < MinRandomPositions) begin
      case (pos)
        6: n = RowCap;
        14: n = RowCap + 1 + $urandom_range(0, 3);
        default: n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                 : $urandom_range(1, 8);
      endcase
      queue_position(n, pos == 6 || pos == 14 || $urandom_range(0, 3) != 0);
      random_rows += n;
      pos++;
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Wait until every row went in and every position came out, then watch a while longer
    // for stray results.
    while (rows_accepted < rows_queued || expected_positions.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    $display("Checked %0d positions from %0d rows; %0d ran past the row store.",
             positions_closed, rows_accepted, overflow_positions);
    $display("Output held off for %0d cycles once; %0d field errors seen.", HoldCycles, errors);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog, far past the slowest legal run.
  initial begin
    #3000000;
    $display("%0t: run timed out", $time);
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/ydph_pkg.sv
design/ydph_ctrl.sv
design/ydph_dp.sv
design/young_diagram_position_hash.sv
test/young_diagram_position_hash_test.sv
